[sv/uoi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uoi_pkg
// Types, constants and the arctangent table for the odometry integrator.
// ----------------------------------------------------------------------------
package uoi_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_STEPS = 24;
  localparam int ATAN_IW = 5;
  localparam int CORD_W = 34;

  localparam logic signed [31:0] CORDIC_START = 32'sd652032874;
  localparam logic signed [31:0] PHASE_PER_RAD_Q30 = 32'sd1367130551;
  localparam logic [15:0] TIME_STEP_RESET = 16'd1311;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] cmd_linear;
    logic signed [15:0] cmd_angular;
  } uoi_in_t;

  typedef struct packed {
    logic signed [31:0] odom_x;
    logic signed [31:0] odom_y;
    logic [15:0]        heading_out;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] echo_linear;
    logic signed [15:0] echo_angular;
  } uoi_out_t;

  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_VDT,
    ST_MUL_WDT,
    ST_MUL_PH,
    ST_ROUND_PH,
    ST_WAIT_C1,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADD_Y,
    ST_WAIT_C2,
    ST_DONE
  } uoi_state_t;

  // Arctangent of 2^-i as a binary angle, 2^32 = 2 pi.
  function automatic logic [31:0] atan_angle(input logic [ATAN_IW-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

[sv/uoi_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uoi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per clock cycle.
// ----------------------------------------------------------------------------
module uoi_cordic
  import uoi_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  localparam int STEPS = (CORDIC_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS : CORDIC_ITERATIONS;
  localparam int ITW = $clog2(STEPS);

  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic signed [CORD_W-1:0] z;
  logic [ITW-1:0]           cnt;
  logic                     flip;

  logic [31:0]              u_turn;
  logic                     need_flip;
  logic [31:0]              u_start;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [CORD_W-1:0] step_angle;

  // Angles outside the right half plane are turned by pi and the result negated.
  always_comb begin
    u_turn = angle + 32'h4000_0000;
    need_flip = u_turn[31];
    u_start = need_flip ? (angle + 32'h8000_0000) : angle;
  end

  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    step_angle = CORD_W'(atan_angle(ATAN_IW'(cnt)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      if (cnt == ITW'(STEPS - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x <= CORD_W'(CORDIC_START);
      y <= '0;
      z <= CORD_W'($signed(u_start));
      flip <= need_flip;
    end else if (busy) begin
      if (!z[CORD_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step_angle;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step_angle;
      end
    end
  end

  assign cos_out = flip ? 32'(-x) : 32'(x);
  assign sin_out = flip ? 32'(-y) : 32'(y);

endmodule

[sv/unicycle_odometry_integrator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicycle_odometry_integrator_unit
// Fixed-point dead-reckoning pose integrator for a differential-drive base.
// ----------------------------------------------------------------------------
// Input beats carry an opcode. A command beat latches the forward velocity
// and yaw rate and produces no result. A tick beat advances the pose with
// the heading from before the tick, then the heading itself, and produces one
// result beat: x, y, heading, yaw quaternion and both velocities.
// The block takes one beat at a time; in_stall stays high while a tick is at
// work. Each tick makes two passes through the single iterative CORDIC, one
// micro-rotation a cycle, over a step count that defaults to 16; the result
// is loaded after the second pass, and the block then returns to idle to
// take the next input beat. The products for the position and heading steps
// share one 32x32 multiplier and overlap the two passes.
// The result sits in an output register; a new input beat is taken while it
// waits, but a finished tick holds until the receiver drops out_stall. Reset
// clears the pose and the latched velocities to zero and loads the time step
// with its default of about 0.02 s. The user must write the time step through
// cfg_we and cfg_wdata while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module unicycle_odometry_integrator_unit
  import uoi_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  uoi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output uoi_out_t out_data,
  input  logic     cfg_we,
  input  logic [15:0] cfg_wdata
);

  uoi_state_t state;
  uoi_state_t state_next;

  logic [15:0]        time_step;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic [31:0]        heading_phase;
  logic signed [15:0] linear_command;
  logic signed [15:0] angular_command;

  logic signed [31:0] vdt;
  logic signed [31:0] cos_reg;
  logic signed [31:0] sin_reg;
  logic signed [63:0] prod;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               cord_start;
  logic [31:0]        cord_angle;
  logic               cord_busy;
  logic signed [31:0] cord_cos;
  logic signed [31:0] cord_sin;

  logic in_accept;
  logic out_free;

  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? $signed(64'(-r)) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [63:0] d);
    logic signed [32:0] sum;
    sum = {a[31], a} + d[32:0];
    if (sum[32] != sum[31]) begin
      return sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return sum[31:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [63:0] r;
    r = round_shift(64'(v), 15);
    if (r > 64'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -64'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  uoi_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cord_start),
    .angle  (cord_angle),
    .busy   (cord_busy),
    .cos_out(cord_cos),
    .sin_out(cord_sin)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && in_data.opcode == OP_TICK) begin
          state_next = ST_MUL_VDT;
        end
      end
      ST_MUL_VDT:  state_next = ST_MUL_WDT;
      ST_MUL_WDT:  state_next = ST_MUL_PH;
      ST_MUL_PH:   state_next = ST_ROUND_PH;
      ST_ROUND_PH: state_next = ST_WAIT_C1;
      ST_WAIT_C1: begin
        if (!cord_busy) begin
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X:    state_next = ST_MUL_Y;
      ST_MUL_Y:    state_next = ST_ADD_Y;
      ST_ADD_Y:    state_next = ST_WAIT_C2;
      ST_WAIT_C2: begin
        if (!cord_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs and the multiplier operand select.
  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    cord_start = 1'b0;
    cord_angle = heading_phase;
    case (state)
      ST_IDLE: begin
        cord_start = in_valid && in_data.opcode == OP_TICK;
        cord_angle = {heading_phase[30:0], 1'b0};
      end
      ST_MUL_VDT: begin
        mul_a = 32'(linear_command);
        mul_b = $signed({16'd0, time_step});
      end
      ST_MUL_WDT: begin
        mul_a = 32'(angular_command);
        mul_b = $signed({16'd0, time_step});
      end
      ST_MUL_PH: begin
        mul_a = prod[31:0];
        mul_b = PHASE_PER_RAD_Q30;
      end
      ST_WAIT_C1: begin
        cord_start = !cord_busy;
      end
      ST_MUL_X: begin
        mul_a = vdt;
        mul_b = cos_reg;
      end
      ST_MUL_Y: begin
        mul_a = vdt;
        mul_b = sin_reg;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      time_step <= TIME_STEP_RESET;
      x_position <= '0;
      y_position <= '0;
      heading_phase <= '0;
      linear_command <= '0;
      angular_command <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        time_step <= cfg_wdata;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && in_data.opcode == OP_COMMAND) begin
            linear_command <= in_data.cmd_linear;
            angular_command <= in_data.cmd_angular;
          end
        end
        ST_ROUND_PH: begin
          heading_phase <= heading_phase + 32'(round_shift(prod, 30));
        end
        ST_MUL_Y: begin
          x_position <= sat_add(x_position, round_shift(prod, 42));
        end
        ST_ADD_Y: begin
          y_position <= sat_add(y_position, round_shift(prod, 42));
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (state == ST_MUL_WDT) begin
      vdt <= prod[31:0];
    end
    if (state == ST_WAIT_C1 && !cord_busy) begin
      cos_reg <= cord_cos;
      sin_reg <= cord_sin;
    end
    if (state == ST_DONE && out_free) begin
      out_data.odom_x <= x_position;
      out_data.odom_y <= y_position;
      out_data.heading_out <= heading_phase[30:15];
      out_data.quat_z <= to_q15(cord_sin);
      out_data.quat_w <= to_q15(cord_cos);
      out_data.echo_linear <= linear_command;
      out_data.echo_angular <= angular_command;
    end
  end

  // A result beat is only ever loaded from the final state of a tick.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result beat appeared outside the final tick state");

  // A command beat must not start the tick sequence.
  a_command_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.opcode == OP_COMMAND) |=> state == ST_IDLE)
    else $error("command beat left the idle state");

  // The first CORDIC pass must be running when the first multiply starts.
  a_cordic_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_VDT) |-> cord_busy)
    else $error("CORDIC not started at tick acceptance");

  // A finished tick waits while the previous result is still held.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> state == ST_DONE)
    else $error("tick result dropped while the output was stalled");

endmodule
